@@ rtl/hrhp_pkg.sv @@
// Package: shared types, constants and helper functions for the request header parser.
`timescale 1ns / 1ps
package hrhp_pkg;

  localparam int unsigned LengthWidthDefault = 32;
  localparam logic [31:0] BufferCapacityReset = 32'd4096;

  // Parse states, one-hot.
  typedef enum logic [22:0] {
    S_MSTART    = 23'd1 << 0,
    S_METHOD    = 23'd1 << 1,
    S_USTART    = 23'd1 << 2,
    S_URI       = 23'd1 << 3,
    S_H         = 23'd1 << 4,
    S_T1        = 23'd1 << 5,
    S_T2        = 23'd1 << 6,
    S_P         = 23'd1 << 7,
    S_SLASH     = 23'd1 << 8,
    S_MAJ0      = 23'd1 << 9,
    S_MAJ       = 23'd1 << 10,
    S_MIN0      = 23'd1 << 11,
    S_MIN       = 23'd1 << 12,
    S_LF1       = 23'd1 << 13,
    S_LINE      = 23'd1 << 14,
    S_LWS       = 23'd1 << 15,
    S_NAME      = 23'd1 << 16,
    S_SPV       = 23'd1 << 17,
    S_VALUE     = 23'd1 << 18,
    S_LF2       = 23'd1 << 19,
    S_LF3       = 23'd1 << 20,
    S_BODY      = 23'd1 << 21,
    S_BODY_OPEN = 23'd1 << 22
  } parse_state_e;

  typedef enum logic [3:0] {
    ST_PROGRESS = 4'd0, ST_BAD = 4'd1, ST_COMPLETE = 4'd2, ST_PARTIAL = 4'd3,
    ST_VERSION = 4'd4, ST_NO_LENGTH = 4'd5, ST_EXPECT = 4'd6, ST_CONT_BODY = 4'd7,
    ST_IGNORED = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    R_SYNTAX = 3'd0, R_METHOD = 3'd1, R_URI = 3'd2, R_NAME = 3'd3, R_VALUE = 3'd4,
    R_BODY = 3'd5
  } role_e;

  typedef enum logic [2:0] {
    HK_NONE = 3'd0, HK_LEN = 3'd1, HK_TE = 3'd2, HK_EXPECT = 3'd3, HK_CONN = 3'd4
  } header_kind_e;

  // One result item.
  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  byte_role;
    logic [7:0]  byte_echo;
    logic [3:0]  method_kind;
    logic [3:0]  version_major;
    logic [3:0]  version_minor;
    logic        keep_alive;
    logic        chunked;
    logic        expect_continue;
    logic [31:0] content_length;
    logic        length_given;
    logic [31:0] body_count;
  } result_t;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
    logic       start_request;
  } item_t;

  // Method name character at a position, zero past the end.
  function automatic logic [7:0] method_char(input logic [2:0] idx, input logic [2:0] pos);
    logic [55:0] s;
    logic [7:0]  c;
    unique case (idx)
      3'd0:    s = {"GET", 32'd0};
      3'd1:    s = {"DELETE", 8'd0};
      3'd2:    s = {"HEAD", 24'd0};
      3'd3:    s = {"TRACE", 16'd0};
      3'd4:    s = "OPTIONS";
      3'd5:    s = {"POST", 24'd0};
      3'd6:    s = {"PUT", 32'd0};
      default: s = {"PATCH", 16'd0};
    endcase
    c = 8'd0;
    if (pos != 3'd7) c = s[55 - 8 * pos -: 8];
    return c;
  endfunction

  function automatic logic [2:0] method_len(input logic [2:0] idx);
    logic [2:0] l;
    unique case (idx)
      3'd0: l = 3'd3; 3'd1: l = 3'd6; 3'd2: l = 3'd4; 3'd3: l = 3'd5;
      3'd4: l = 3'd7; 3'd5: l = 3'd4; 3'd6: l = 3'd3; default: l = 3'd5;
    endcase
    return l;
  endfunction

  // Header name character, lowercase.
  function automatic logic [7:0] name_char(input logic [1:0] idx, input logic [4:0] pos);
    logic [135:0] s;
    logic [4:0]   len;
    logic [7:0]   c;
    unique case (idx)
      2'd0: begin s = {"content-length", 24'd0}; len = 5'd14; end
      2'd1: begin s = "transfer-encoding"; len = 5'd17; end
      2'd2: begin s = {"expect", 88'd0}; len = 5'd6; end
      default: begin s = {"connection", 56'd0}; len = 5'd10; end
    endcase
    c = 8'd0;
    if (pos < len) c = s[135 - 8 * pos -: 8];
    return c;
  endfunction

  function automatic logic [4:0] name_len(input logic [1:0] idx);
    logic [4:0] l;
    unique case (idx)
      2'd0: l = 5'd14; 2'd1: l = 5'd17; 2'd2: l = 5'd6; default: l = 5'd10;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] value_char(input logic [1:0] idx, input logic [3:0] pos);
    logic [95:0] s;
    logic [3:0]  len;
    logic [7:0]  c;
    unique case (idx)
      2'd0: begin s = {"chunked", 40'd0}; len = 4'd7; end
      2'd1: begin s = "100-continue"; len = 4'd12; end
      2'd2: begin s = {"keep-alive", 16'd0}; len = 4'd10; end
      default: begin s = {"close", 56'd0}; len = 4'd5; end
    endcase
    c = 8'd0;
    if (pos < len) c = s[95 - 8 * pos -: 8];
    return c;
  endfunction

  function automatic logic [3:0] value_len(input logic [1:0] idx);
    logic [3:0] l;
    unique case (idx)
      2'd0: l = 4'd7; 2'd1: l = 4'd12; 2'd2: l = 4'd10; default: l = 4'd5;
    endcase
    return l;
  endfunction

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= 8'd31) || (c == 8'd127);
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    logic sp;
    unique case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
      "=", "{", "}", " ", 8'h09: sp = 1'b1;
      default: sp = 1'b0;
    endcase
    return !c[7] && !is_ctl(c) && !sp;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // acc*10+d saturating at 15.
  function automatic logic [3:0] sat_digit4(input logic [3:0] acc, input logic [3:0] d);
    logic [7:0] v;
    v = {4'd0, acc} * 8'd10 + {4'd0, d};
    return (v > 8'd15) ? 4'd15 : v[3:0];
  endfunction

endpackage

@@ rtl/hrhp_if.sv @@
// Interface: valid/ready channel carrying one payload item.
`timescale 1ns / 1ps
interface hrhp_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/hrhp_core.sv @@
// Core: per-byte parse state, matchers, accumulators and result logic.
`timescale 1ns / 1ps
module hrhp_core
  import hrhp_pkg::*;
#(
  parameter int unsigned LengthWidth = LengthWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  item_t       item_i,
  input  logic [31:0] capacity_i,
  output result_t     result_o
);

  localparam logic [LengthWidth-1:0] LenMax = '1;

  parse_state_e           state_q, state_d;
  logic [7:0]             mmatch_q, mmatch_d;
  logic [2:0]             mpos_q, mpos_d;
  logic [3:0]             nmatch_q, nmatch_d;
  logic [4:0]             npos_q, npos_d;
  logic [3:0]             vmatch_q, vmatch_d;
  logic [3:0]             vpos_q, vpos_d;
  header_kind_e           hkind_q, hkind_d;
  logic [3:0]             major_q, major_d, minor_q, minor_d;
  logic                   keep_q, keep_d, chunk_q, chunk_d, expect_q, expect_d;
  logic                   len_q, len_d, hdr_q, hdr_d, done_q, done_d;
  logic [1:0]             phase_q, phase_d;
  logic [LengthWidth-1:0] lacc_q, lacc_d, rem_q, rem_d, decl_q, decl_d;
  logic [31:0]            body_q, body_d, bufb_q, bufb_d;

  // Start-of-request view of the state.
  parse_state_e           s0;
  logic [7:0]             mm0;
  logic [2:0]             mp0;
  logic [3:0]             nm0, vm0, ma0, mi0;
  logic [4:0]             np0;
  logic [3:0]             vp0;
  header_kind_e           hk0;
  logic                   k0, c0, e0, l0, h0, d0;
  logic [1:0]             ph0;
  logic [LengthWidth-1:0] la0, rm0, dl0;
  logic [31:0]            bc0, bb;

  logic [7:0]             c;
  logic [3:0]             status;
  logic [2:0]             role;
  logic [3:0]             kind_now, kind_out;
  logic [LengthWidth+3:0] lmul;
  logic [3:0]             dig;

  // Method kind from a match vector and position.
  function automatic logic [3:0] kind_of(input logic [7:0] m, input logic [2:0] p);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i] && p == method_len(3'(i))) k = 4'(i + 1);
    end
    return k;
  endfunction

  function automatic logic full4v(input logic [3:0] m, input logic [3:0] p,
                                  input logic [1:0] i);
    return m[i] && p == value_len(i);
  endfunction

  assign c   = item_i.data_byte;
  assign dig = c[3:0];

  always_comb begin
    s0 = state_q; mm0 = mmatch_q; mp0 = mpos_q; nm0 = nmatch_q; np0 = npos_q;
    vm0 = vmatch_q; vp0 = vpos_q; hk0 = hkind_q; ma0 = major_q; mi0 = minor_q;
    k0 = keep_q; c0 = chunk_q; e0 = expect_q; l0 = len_q; h0 = hdr_q; d0 = done_q;
    ph0 = phase_q; la0 = lacc_q; rm0 = rem_q; dl0 = decl_q; bc0 = body_q;
    if (item_i.start_request) begin
      s0 = S_MSTART; mm0 = 8'hFF; mp0 = '0; nm0 = 4'hF; np0 = '0; vm0 = 4'hF;
      vp0 = '0; hk0 = HK_NONE; ma0 = '0; mi0 = '0; k0 = 1'b0; c0 = 1'b0;
      e0 = 1'b0; l0 = 1'b0; h0 = 1'b0; d0 = 1'b0; ph0 = '0; la0 = '0; rm0 = '0;
      dl0 = '0; bc0 = '0;
    end
    bb = (bufb_q != 32'hFFFF_FFFF) ? bufb_q + 32'd1 : bufb_q;
  end

  // Advance the parser by one byte.
  always_comb begin
    logic [3:0] k;
    state_d = s0; mmatch_d = mm0; mpos_d = mp0; nmatch_d = nm0; npos_d = np0;
    vmatch_d = vm0; vpos_d = vp0; hkind_d = hk0; major_d = ma0; minor_d = mi0;
    keep_d = k0; chunk_d = c0; expect_d = e0; len_d = l0; hdr_d = h0; done_d = d0;
    phase_d = ph0; lacc_d = la0; rem_d = rm0; decl_d = dl0; body_d = bc0;
    status = ST_PROGRESS; role = R_SYNTAX; lmul = '0;
    k = kind_of(mm0, mp0);

    if (d0) begin
      status = ST_IGNORED;
    end else begin
      unique case (s0)
        S_MSTART, S_METHOD: begin
          if (s0 == S_METHOD && c == " ") begin
            state_d = S_USTART;
          end else if (!is_token(c)) begin
            status = ST_BAD;
          end else begin
            if (mp0 >= 3'd7) begin
              mmatch_d = '0;
            end else begin
              for (int i = 0; i < 8; i++) begin
                if (mp0 >= method_len(3'(i)) || method_char(3'(i), mp0) != c)
                  mmatch_d[i] = 1'b0;
              end
              mpos_d = mp0 + 3'd1;
            end
            role = R_METHOD; state_d = S_METHOD;
          end
        end
        S_USTART, S_URI: begin
          if (s0 == S_URI && c == " ") state_d = S_H;
          else if (is_ctl(c)) status = ST_BAD;
          else begin role = R_URI; state_d = S_URI; end
        end
        S_H:  if (c != "H") status = ST_BAD; else state_d = S_T1;
        S_T1: if (c != "T") status = ST_BAD; else state_d = S_T2;
        S_T2: if (c != "T") status = ST_BAD; else state_d = S_P;
        S_P:  if (c != "P") status = ST_BAD; else state_d = S_SLASH;
        S_SLASH: begin
          if (c != "/") status = ST_BAD;
          else begin major_d = '0; minor_d = '0; state_d = S_MAJ0; end
        end
        S_MAJ0, S_MAJ: begin
          if (s0 == S_MAJ && c == ".") state_d = S_MIN0;
          else if (!is_digit(c)) status = ST_BAD;
          else begin major_d = sat_digit4(ma0, dig); state_d = S_MAJ; end
        end
        S_MIN0, S_MIN: begin
          if (s0 == S_MIN && c == 8'h0D) state_d = S_LF1;
          else if (!is_digit(c)) status = ST_BAD;
          else begin minor_d = sat_digit4(mi0, dig); state_d = S_MIN; end
        end
        S_LF1: begin
          if (c != 8'h0A) status = ST_BAD;
          else begin
            state_d = S_LINE;
            if (ma0 > 4'd1 || (ma0 == 4'd1 && mi0 > 4'd1)) status = ST_VERSION;
            else keep_d = (ma0 == 4'd1 && mi0 > 4'd0);
          end
        end
        S_LINE, S_NAME: begin
          logic [3:0] nm;
          logic [4:0] np;
          nm = nm0; np = np0;
          if (s0 == S_LINE && c == 8'h0D) begin
            state_d = S_LF3;
          end else if (s0 == S_LINE && h0 && (c == " " || c == 8'h09)) begin
            state_d = S_LWS;
          end else if (s0 == S_NAME && c == ":") begin
            for (int i = 0; i < 4; i++)
              if (nm0[i] && np0 == name_len(2'(i))) hkind_d = header_kind_e'(3'(i + 1));
            state_d = S_SPV;
          end else if (!is_token(c)) begin
            status = ST_BAD;
          end else begin
            if (s0 == S_LINE) begin
              nm = 4'hF; np = '0; vmatch_d = 4'hF; vpos_d = '0; hkind_d = HK_NONE;
              lacc_d = '0; phase_d = '0; hdr_d = 1'b1; state_d = S_NAME;
            end
            for (int i = 0; i < 4; i++)
              if (np >= name_len(2'(i)) || name_char(2'(i), np) != to_lower(c))
                nm[i] = 1'b0;
            nmatch_d = nm;
            npos_d = (np < 5'd31) ? np + 5'd1 : np;
            role = R_NAME;
          end
        end
        S_SPV: if (c != " ") status = ST_BAD; else state_d = S_VALUE;
        S_LWS, S_VALUE: begin
          if (c == 8'h0D) begin
            state_d = S_LF2;
            if (s0 == S_VALUE) begin
              unique case (hk0)
                HK_LEN: begin decl_d = la0; rem_d = la0; len_d = 1'b1; end
                HK_TE: if (full4v(vm0, vp0, 2'd0)) chunk_d = 1'b1;
                HK_EXPECT: if (full4v(vm0, vp0, 2'd1)) expect_d = 1'b1;
                HK_CONN: begin
                  if (ma0 == 4'd1 && mi0 < 4'd1) begin
                    if (full4v(vm0, vp0, 2'd2)) keep_d = 1'b1;
                  end else if (full4v(vm0, vp0, 2'd3)) keep_d = 1'b0;
                end
                default: ;
              endcase
            end
          end else if (s0 == S_LWS && (c == " " || c == 8'h09)) begin
            state_d = S_LWS;
          end else if (is_ctl(c)) begin
            status = ST_BAD;
          end else begin
            for (int i = 0; i < 4; i++)
              if (vp0 >= value_len(2'(i)) || value_char(2'(i), vp0) != to_lower(c))
                vmatch_d[i] = 1'b0;
            if (vp0 < 4'd15) vpos_d = vp0 + 4'd1;
            if (!(ph0 == 2'd0 && c == " ")) begin
              if (ph0 <= 2'd1 && is_digit(c)) begin
                lmul = {4'd0, la0} * (LengthWidth + 4)'(10) + (LengthWidth + 4)'(dig);
                lacc_d = (lmul > {4'd0, LenMax}) ? LenMax : lmul[LengthWidth-1:0];
                phase_d = 2'd1;
              end else begin
                phase_d = 2'd2;
              end
            end
            role = R_VALUE; state_d = S_VALUE;
          end
        end
        S_LF2: if (c != 8'h0A) status = ST_BAD; else state_d = S_LINE;
        S_LF3: begin
          logic early;
          early = 1'b0;
          if (k >= 4'd1 && k <= 4'd5) begin
            if (e0 || c0 || l0) begin status = ST_BAD; early = 1'b1; end
            else rem_d = '0;
          end else if (k >= 4'd6 && ma0 == 4'd1 && mi0 > 4'd0) begin
            if (c0) begin status = l0 ? ST_BAD : ST_NO_LENGTH; early = 1'b1; end
            else if (!l0) begin status = ST_NO_LENGTH; early = 1'b1; end
            else if (e0) begin
              status = item_i.end_of_buffer ? ST_EXPECT : ST_CONT_BODY; early = 1'b1;
            end
          end
          if (!early) begin
            if (c != 8'h0A) status = ST_BAD;
            else if (k >= 4'd1 && k <= 4'd5) status = ST_COMPLETE;
            else if (!l0) begin body_d = '0; state_d = S_BODY_OPEN; end
            else if (rm0 == '0) status = ST_COMPLETE;
            else begin body_d = '0; state_d = S_BODY; end
          end
        end
        S_BODY: begin
          role = R_BODY;
          if (bc0 != 32'hFFFF_FFFF) body_d = bc0 + 32'd1;
          rem_d = rm0 - LengthWidth'(1);
          if (rem_d == '0) status = ST_COMPLETE;
        end
        S_BODY_OPEN: begin
          role = R_BODY;
          if (bc0 != 32'hFFFF_FFFF) body_d = bc0 + 32'd1;
        end
        default: status = ST_BAD;
      endcase

      // End of buffer with nothing else to report.
      if (status == ST_PROGRESS && item_i.end_of_buffer) begin
        if (state_d == S_BODY_OPEN && bb < capacity_i) begin
          decl_d = LengthWidth'(body_d); len_d = 1'b1; status = ST_COMPLETE;
        end else begin
          status = ST_PARTIAL;
        end
      end
      if (status != ST_PROGRESS && status != ST_PARTIAL) done_d = 1'b1;
    end
    bufb_d = item_i.end_of_buffer ? 32'd0 : bb;
  end

  assign kind_out = kind_of(mmatch_d, mpos_d);
  assign kind_now = kind_out;

  // Hold state; advance on each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_MSTART; mmatch_q <= 8'hFF; mpos_q <= '0; nmatch_q <= 4'hF;
      npos_q <= '0; vmatch_q <= 4'hF; vpos_q <= '0; hkind_q <= HK_NONE;
      major_q <= '0; minor_q <= '0; keep_q <= 1'b0; chunk_q <= 1'b0;
      expect_q <= 1'b0; len_q <= 1'b0; hdr_q <= 1'b0; done_q <= 1'b0;
      phase_q <= '0; lacc_q <= '0; rem_q <= '0; decl_q <= '0; body_q <= '0;
      bufb_q <= '0;
    end else if (step_i) begin
      state_q <= state_d; mmatch_q <= mmatch_d; mpos_q <= mpos_d;
      nmatch_q <= nmatch_d; npos_q <= npos_d; vmatch_q <= vmatch_d;
      vpos_q <= vpos_d; hkind_q <= hkind_d; major_q <= major_d; minor_q <= minor_d;
      keep_q <= keep_d; chunk_q <= chunk_d; expect_q <= expect_d; len_q <= len_d;
      hdr_q <= hdr_d; done_q <= done_d; phase_q <= phase_d; lacc_q <= lacc_d;
      rem_q <= rem_d; decl_q <= decl_d; body_q <= body_d; bufb_q <= bufb_d;
    end
  end

  always_comb begin
    result_o.status          = status;
    result_o.byte_role       = role;
    result_o.byte_echo       = c;
    result_o.method_kind     = kind_now;
    result_o.version_major   = major_d;
    result_o.version_minor   = minor_d;
    result_o.keep_alive      = keep_d;
    result_o.chunked         = chunk_d;
    result_o.expect_continue = expect_d;
    result_o.content_length  = 32'(decl_d);
    result_o.length_given    = len_d;
    result_o.body_count      = body_d;
  end

endmodule

@@ rtl/http_request_header_parser.sv @@
// Top level: input register, parser core and output register with skid stage.
`timescale 1ns / 1ps
// HTTP request header parser. One request byte enters per cycle unless the
// input stalls, and yields one result item: the input register feeds the
// parse core, whose result goes to an output register backed by a skid
// stage, so one more item is taken while a result waits and the input stalls
// only once the skid stage is full. buffer_capacity is to be written through
// cfg_we_i/cfg_wdata_i only while the block is idle; the block does not check it.
module http_request_header_parser
  import hrhp_pkg::*;
#(
  parameter int unsigned LengthWidth = LengthWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  hrhp_if.sink        in_i,
  hrhp_if.source      out_o
);

  logic [31:0] cap_q;
  logic        in_v_q;
  item_t       in_q;
  result_t     res;
  logic        out_v_q, skid_v_q;
  result_t     out_q, skid_q;
  logic        step;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= BufferCapacityReset;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  // Core consumes the input register when the skid stage is free.
  assign step     = in_v_q && !skid_v_q;
  assign in_i.ready = !in_v_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_v_q <= 1'b0;
    else if (in_i.ready) in_v_q <= in_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) in_q <= in_i.payload;
  end

  hrhp_core #(.LengthWidth(LengthWidth)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .capacity_i (cap_q),
    .result_o   (res)
  );

  // Output register with skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || out_o.ready) begin
        out_v_q  <= skid_v_q || step;
        skid_v_q <= 1'b0;
      end else if (step) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_o.ready) out_q <= skid_v_q ? skid_q : res;
    if (step && out_v_q && !out_o.ready) skid_q <= res;
  end

  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;

endmodule

@@ verif/tb_http_request_header_parser.sv @@
// Testbench: random and directed HTTP request bytes checked against a built-in parser model.
`timescale 1ns / 1ps

// Expected-result store and the parser model that fills it.
class hdr_scoreboard;
  typedef enum int {
    P_MSTART, P_METHOD, P_USTART, P_URI, P_H, P_T1, P_T2, P_P, P_SLASH,
    P_MAJ0, P_MAJ, P_MIN0, P_MIN, P_LF1, P_LINE, P_LWS, P_NAME, P_SPV,
    P_VALUE, P_LF2, P_LF3, P_BODY, P_BODY_OPEN
  } pstate_e;

  localparam longint unsigned LenMax = 64'hFFFF_FFFF;

  hrhp_pkg::result_t expected_q[$];
  int          errors;
  logic [31:0] capacity;
  string       meth_tab[8];
  string       name_tab[4];
  string       val_tab[4];

  pstate_e                st;
  logic [7:0]             mmatch;
  int                     mpos;
  logic [3:0]             nmatch, vmatch;
  int                     npos, vpos;
  hrhp_pkg::header_kind_e hk;
  int                     vmaj, vmin, numph;
  bit                     keep, chunk, expct, len_known, hdr_seen, done;
  longint unsigned        lacc, remain, declared;
  logic [31:0]            bodyc, bufb;

  function new();
    meth_tab = '{"GET", "DELETE", "HEAD", "TRACE", "OPTIONS", "POST", "PUT", "PATCH"};
    name_tab = '{"content-length", "transfer-encoding", "expect", "connection"};
    val_tab  = '{"chunked", "100-continue", "keep-alive", "close"};
    errors   = 0;
    capacity = 32'd4096;
    bufb     = 0;
    clear_request();
  endfunction

  function void clear_request();
    st = P_MSTART; mmatch = 8'hFF; mpos = 0;
    nmatch = 4'hF; npos = 0; vmatch = 4'hF; vpos = 0;
    hk = hrhp_pkg::HK_NONE; vmaj = 0; vmin = 0; numph = 0;
    keep = 0; chunk = 0; expct = 0; len_known = 0; hdr_seen = 0; done = 0;
    lacc = 0; remain = 0; declared = 0; bodyc = 0;
  endfunction

  function bit ctl(logic [7:0] c);
    return c <= 8'd31 || c == 8'd127;
  endfunction

  function bit token(logic [7:0] c);
    bit sp;
    sp = 0;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
      "=", "{", "}", " ", 8'h09: sp = 1;
      default: sp = 0;
    endcase
    return c < 8'd128 && !ctl(c) && !sp;
  endfunction

  function logic [7:0] lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function int sat15(int acc, int d);
    int v;
    v = acc * 10 + d;
    return v > 15 ? 15 : v;
  endfunction

  // Narrow the header-name or value candidates by one lowercased byte.
  function logic [3:0] narrow(logic [3:0] live, int pos, logic [7:0] c, bit vals);
    string s;
    for (int i = 0; i < 4; i++) begin
      s = vals ? val_tab[i] : name_tab[i];
      if (pos >= s.len() || s[pos] != lower(c)) live[i] = 1'b0;
    end
    return live;
  endfunction

  function bit whole(logic [3:0] live, int pos, int i, bit vals);
    string s;
    s = vals ? val_tab[i] : name_tab[i];
    return live[i] && pos == s.len();
  endfunction

  function logic [3:0] method_code();
    for (int i = 0; i < 8; i++)
      if (mmatch[i] && mpos == meth_tab[i].len()) return 4'(i + 1);
    return 4'd0;
  endfunction

  function void method_byte(logic [7:0] c);
    if (mpos >= 7) begin
      mmatch = 0;
      return;
    end
    for (int i = 0; i < 8; i++)
      if (mpos >= meth_tab[i].len() || meth_tab[i][mpos] != c) mmatch[i] = 1'b0;
    mpos++;
  endfunction

  // Feed one value byte to the candidates and the length accumulator.
  function void value_byte(logic [7:0] c);
    longint unsigned d;
    vmatch = narrow(vmatch, vpos, c, 1);
    if (vpos < 15) vpos++;
    if (numph == 0 && c == " ") return;
    if (numph <= 1 && digit(c)) begin
      d = c - "0";
      lacc = (lacc > (LenMax - d) / 10) ? LenMax : lacc * 10 + d;
      numph = 1;
    end else begin
      numph = 2;
    end
  endfunction

  function void store_header();
    case (hk)
      hrhp_pkg::HK_LEN: begin
        declared = lacc; remain = lacc; len_known = 1;
      end
      hrhp_pkg::HK_TE: if (whole(vmatch, vpos, 0, 1)) chunk = 1;
      hrhp_pkg::HK_EXPECT: if (whole(vmatch, vpos, 1, 1)) expct = 1;
      hrhp_pkg::HK_CONN: begin
        if (vmaj == 1 && vmin < 1) begin
          if (whole(vmatch, vpos, 2, 1)) keep = 1;
        end else if (whole(vmatch, vpos, 3, 1)) begin
          keep = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // Apply method, length, chunked and expect rules after the blank line.
  function hrhp_pkg::status_e close_head(logic [7:0] c, bit eob);
    logic [3:0] k;
    k = method_code();
    if (k >= 1 && k <= 5) begin
      if (expct || chunk || len_known) return hrhp_pkg::ST_BAD;
      remain = 0;
    end else if (k >= 6 && vmaj == 1 && vmin > 0) begin
      if (chunk) return len_known ? hrhp_pkg::ST_BAD : hrhp_pkg::ST_NO_LENGTH;
      if (!len_known) return hrhp_pkg::ST_NO_LENGTH;
      if (expct) return eob ? hrhp_pkg::ST_EXPECT : hrhp_pkg::ST_CONT_BODY;
    end
    if (c != 8'h0A) return hrhp_pkg::ST_BAD;
    if (k >= 1 && k <= 5) return hrhp_pkg::ST_COMPLETE;
    if (!len_known) begin
      bodyc = 0; st = P_BODY_OPEN;
      return hrhp_pkg::ST_PROGRESS;
    end
    if (remain == 0) return hrhp_pkg::ST_COMPLETE;
    bodyc = 0; st = P_BODY;
    return hrhp_pkg::ST_PROGRESS;
  endfunction

  function hrhp_pkg::status_e name_byte(logic [7:0] c, output hrhp_pkg::role_e role);
    role = hrhp_pkg::R_SYNTAX;
    if (c == ":") begin
      for (int i = 0; i < 4; i++)
        if (whole(nmatch, npos, i, 0)) hk = hrhp_pkg::header_kind_e'(i + 1);
      st = P_SPV;
      return hrhp_pkg::ST_PROGRESS;
    end
    if (!token(c)) return hrhp_pkg::ST_BAD;
    nmatch = narrow(nmatch, npos, c, 0);
    if (npos < 31) npos++;
    role = hrhp_pkg::R_NAME;
    return hrhp_pkg::ST_PROGRESS;
  endfunction

  // Advance the parse state by one byte.
  function hrhp_pkg::status_e walk(logic [7:0] c, bit eob, output hrhp_pkg::role_e role);
    role = hrhp_pkg::R_SYNTAX;
    case (st)
      P_MSTART: begin
        if (!token(c)) return hrhp_pkg::ST_BAD;
        method_byte(c); role = hrhp_pkg::R_METHOD; st = P_METHOD;
      end
      P_METHOD: begin
        if (c == " ") st = P_USTART;
        else if (!token(c)) return hrhp_pkg::ST_BAD;
        else begin
          method_byte(c); role = hrhp_pkg::R_METHOD;
        end
      end
      P_USTART: begin
        if (ctl(c)) return hrhp_pkg::ST_BAD;
        role = hrhp_pkg::R_URI; st = P_URI;
      end
      P_URI: begin
        if (c == " ") st = P_H;
        else if (ctl(c)) return hrhp_pkg::ST_BAD;
        else role = hrhp_pkg::R_URI;
      end
      P_H: begin
        if (c != "H") return hrhp_pkg::ST_BAD;
        st = P_T1;
      end
      P_T1: begin
        if (c != "T") return hrhp_pkg::ST_BAD;
        st = P_T2;
      end
      P_T2: begin
        if (c != "T") return hrhp_pkg::ST_BAD;
        st = P_P;
      end
      P_P: begin
        if (c != "P") return hrhp_pkg::ST_BAD;
        st = P_SLASH;
      end
      P_SLASH: begin
        if (c != "/") return hrhp_pkg::ST_BAD;
        vmaj = 0; vmin = 0; st = P_MAJ0;
      end
      P_MAJ0, P_MAJ: begin
        if (st == P_MAJ && c == ".") st = P_MIN0;
        else if (!digit(c)) return hrhp_pkg::ST_BAD;
        else begin
          vmaj = sat15(vmaj, c - "0"); st = P_MAJ;
        end
      end
      P_MIN0, P_MIN: begin
        if (st == P_MIN && c == 8'h0D) st = P_LF1;
        else if (!digit(c)) return hrhp_pkg::ST_BAD;
        else begin
          vmin = sat15(vmin, c - "0"); st = P_MIN;
        end
      end
      P_LF1: begin
        if (c != 8'h0A) return hrhp_pkg::ST_BAD;
        st = P_LINE;
        if (vmaj > 1 || (vmaj == 1 && vmin > 1)) return hrhp_pkg::ST_VERSION;
        keep = (vmaj == 1 && vmin > 0);
      end
      P_LINE: begin
        if (c == 8'h0D) st = P_LF3;
        else if (hdr_seen && (c == " " || c == 8'h09)) st = P_LWS;
        else if (!token(c)) return hrhp_pkg::ST_BAD;
        else begin
          nmatch = 4'hF; npos = 0; vmatch = 4'hF; vpos = 0;
          hk = hrhp_pkg::HK_NONE; lacc = 0; numph = 0; hdr_seen = 1;
          st = P_NAME;
          return name_byte(c, role);
        end
      end
      P_NAME: return name_byte(c, role);
      P_SPV: begin
        if (c != " ") return hrhp_pkg::ST_BAD;
        st = P_VALUE;
      end
      P_LWS: begin
        if (c == 8'h0D) st = P_LF2;
        else if (c == " " || c == 8'h09) ;
        else if (ctl(c)) return hrhp_pkg::ST_BAD;
        else begin
          value_byte(c); role = hrhp_pkg::R_VALUE; st = P_VALUE;
        end
      end
      P_VALUE: begin
        if (c == 8'h0D) begin
          store_header(); st = P_LF2;
        end else if (ctl(c)) return hrhp_pkg::ST_BAD;
        else begin
          value_byte(c); role = hrhp_pkg::R_VALUE;
        end
      end
      P_LF2: begin
        if (c != 8'h0A) return hrhp_pkg::ST_BAD;
        st = P_LINE;
      end
      P_LF3: return close_head(c, eob);
      P_BODY: begin
        role = hrhp_pkg::R_BODY;
        if (bodyc != 32'hFFFF_FFFF) bodyc++;
        remain--;
        return remain == 0 ? hrhp_pkg::ST_COMPLETE : hrhp_pkg::ST_PROGRESS;
      end
      P_BODY_OPEN: begin
        role = hrhp_pkg::R_BODY;
        if (bodyc != 32'hFFFF_FFFF) bodyc++;
      end
      default: return hrhp_pkg::ST_BAD;
    endcase
    return hrhp_pkg::ST_PROGRESS;
  endfunction

  // Work out the result of one accepted input byte and queue it.
  function void note_input(hrhp_pkg::item_t it);
    hrhp_pkg::result_t r;
    hrhp_pkg::status_e s;
    hrhp_pkg::role_e   role;
    role = hrhp_pkg::R_SYNTAX;
    if (it.start_request) clear_request();
    if (bufb != 32'hFFFF_FFFF) bufb++;
    if (done) begin
      s = hrhp_pkg::ST_IGNORED;
    end else begin
      s = walk(it.data_byte, it.end_of_buffer, role);
      if (s == hrhp_pkg::ST_PROGRESS && it.end_of_buffer) begin
        if (st == P_BODY_OPEN && bufb < capacity) begin
          declared = bodyc; len_known = 1; s = hrhp_pkg::ST_COMPLETE;
        end else begin
          s = hrhp_pkg::ST_PARTIAL;
        end
      end
      if (s != hrhp_pkg::ST_PROGRESS && s != hrhp_pkg::ST_PARTIAL) done = 1;
    end
    if (it.end_of_buffer) bufb = 0;
    r.status          = s;
    r.byte_role       = role;
    r.byte_echo       = it.data_byte;
    r.method_kind     = method_code();
    r.version_major   = 4'(vmaj);
    r.version_minor   = 4'(vmin);
    r.keep_alive      = keep;
    r.chunked         = chunk;
    r.expect_continue = expct;
    r.content_length  = declared[31:0];
    r.length_given    = len_known;
    r.body_count      = bodyc;
    expected_q.insert(expected_q.size(), r);
  endfunction

  task report(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  // Compare one result field by field with the oldest expectation.
  task check_result(hrhp_pkg::result_t g);
    hrhp_pkg::result_t w;
    if (expected_q.size() == 0) begin
      report("unexpected result", g.byte_echo, 0);
      return;
    end
    w = expected_q.pop_front();
    if (g.status !== w.status) report("status", g.status, w.status);
    if (g.byte_role !== w.byte_role) report("byte_role", g.byte_role, w.byte_role);
    if (g.byte_echo !== w.byte_echo) report("byte_echo", g.byte_echo, w.byte_echo);
    if (g.method_kind !== w.method_kind) report("method_kind", g.method_kind, w.method_kind);
    if (g.version_major !== w.version_major)
      report("version_major", g.version_major, w.version_major);
    if (g.version_minor !== w.version_minor)
      report("version_minor", g.version_minor, w.version_minor);
    if (g.keep_alive !== w.keep_alive) report("keep_alive", g.keep_alive, w.keep_alive);
    if (g.chunked !== w.chunked) report("chunked", g.chunked, w.chunked);
    if (g.expect_continue !== w.expect_continue)
      report("expect_continue", g.expect_continue, w.expect_continue);
    if (g.content_length !== w.content_length)
      report("content_length", g.content_length, w.content_length);
    if (g.length_given !== w.length_given)
      report("length_given", g.length_given, w.length_given);
    if (g.body_count !== w.body_count) report("body_count", g.body_count, w.body_count);
  endtask
endclass

module tb_http_request_header_parser;
  localparam int StallLimit = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  bit          no_gaps;
  bit          long_hold;
  int          idle_cycles;
  int          sent;
  byte unsigned req_q[$];
  hdr_scoreboard sb;

  hrhp_if #(.T(hrhp_pkg::item_t))   in_if ();
  hrhp_if #(.T(hrhp_pkg::result_t)) out_if ();

  http_request_header_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hand one item to the block and wait for it to be taken.
  task automatic send_item(logic [7:0] b, bit eob, bit start);
    hrhp_pkg::item_t it;
    int gap;
    it.data_byte = b; it.end_of_buffer = eob; it.start_request = start;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(it);
    sent++;
  endtask

  // Drop valid and hold until every expected result is back, then settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.capacity = v;
    @(posedge clk_i);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) req_q.insert(req_q.size(), s[i]);
  endtask

  function automatic string mix_case(string s);
    for (int i = 0; i < s.len(); i++)
      if ($urandom_range(0, 1) == 1) begin
        if (s[i] >= "a" && s[i] <= "z") s[i] = s[i] - 8'd32;
        else if (s[i] >= "A" && s[i] <= "Z") s[i] = s[i] + 8'd32;
      end
    return s;
  endfunction

  // Build one mostly well-formed request into req_q.
  task automatic make_request();
    string meths[11];
    string vers[10];
    int body_len, nh, nb;
    meths = '{"GET", "DELETE", "HEAD", "TRACE", "OPTIONS", "POST", "PUT", "PATCH",
              "get", "OPTIONSX", "BREW"};
    vers  = '{"1.1", "1.1", "1.1", "1.1", "1.0", "1.0", "2.0", "1.2", "0.9", "123.45"};
    body_len = -1;
    req_q.delete();
    push_text(meths[$urandom_range(0, 10)]);
    push_text(" /");
    repeat ($urandom_range(0, 4)) req_q.insert(req_q.size(), 8'($urandom_range(33, 126)));
    push_text(" HTTP/");
    push_text(vers[$urandom_range(0, 9)]);
    push_text("\r\n");
    nh = $urandom_range(0, 3);
    for (int h = 0; h < nh; h++) begin
      case ($urandom_range(0, 8))
        0, 1: begin
          body_len = $urandom_range(0, 6);
          push_text({mix_case("Content-Length"), ": "});
          case ($urandom_range(0, 9))
            0: push_text({"  ", $sformatf("%0d", body_len)});
            1: push_text("99999999999");
            2: push_text("-3");
            3: push_text("x");
            default: push_text($sformatf("%0d", body_len));
          endcase
        end
        2: push_text({mix_case("Transfer-Encoding"), ": ", mix_case("chunked")});
        3: push_text({mix_case("Expect"), ": ", mix_case("100-continue")});
        4: push_text({mix_case("Connection"), ": ",
                      mix_case($urandom_range(0, 1) ? string'("close")
                                                    : string'("Keep-Alive"))});
        5: push_text("Host: h");
        6: push_text("X-A: 1\r\n\tmore");
        7: begin
          body_len = 12;
          push_text("Content-Length: 1\r\n 2");
        end
        default: push_text("Content-Lengthy: 5");
      endcase
      push_text("\r\n");
    end
    push_text("\r\n");
    nb = (body_len >= 0) ? body_len + $urandom_range(0, 1) : $urandom_range(0, 5);
    repeat (nb) req_q.insert(req_q.size(), 8'($urandom));
    // Corrupt one byte now and then.
    if ($urandom_range(0, 9) == 0)
      req_q[$urandom_range(0, req_q.size() - 1)] = 8'($urandom);
  endtask

  task automatic send_request();
    bit eob, start;
    for (int i = 0; i < req_q.size(); i++) begin
      start = (i == 0) || ($urandom_range(0, 79) == 0);
      eob = (i == req_q.size() - 1) ? $urandom_range(0, 1) : ($urandom_range(0, 24) == 0);
      send_item(req_q[i], eob, start);
    end
  endtask

  // Receiver: random stall per item, one long hold-off, check every result.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        stall = 80;
        long_hold = 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 3);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      sb.check_result(out_if.payload);
    end
  end

  // Abort when no item moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] caps[5];
    caps = '{32'd4096, 32'd1, 32'hFFFF_FFFF, 32'd40, 32'd12};
    sb = new();
    idle_cycles = 0;
    sent = 0;
    no_gaps = 0;
    long_hold = 0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: open-length POST over 1.0 ended by the buffer, an ignored byte,
    // then a restart on a control byte.
    req_q.delete();
    push_text("POST / HTTP/1.0\r\n\r\nab");
    for (int i = 0; i < req_q.size(); i++)
      send_item(req_q[i], i == req_q.size() - 1, i == 0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    drain();

    // Random phases, each under its own buffer capacity.
    for (int p = 0; p < 5; p++) begin
      if (p > 0) write_capacity(caps[p]);
      if (p == 2) long_hold = 1;
      sent = 0;
      while (sent < 80) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) begin
          req_q.delete();
          repeat ($urandom_range(1, 6)) req_q.insert(req_q.size(), 8'($urandom));
        end else begin
          make_request();
        end
        send_request();
      end
      no_gaps = 0;
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
